@@ rtl/row_kernel_upsampler_top_assert.svh @@
// ----------------------------------------------------------------------------
// Row kernel upsampler assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ROW_KERNEL_UPSAMPLER_TOP_ASSERT_SVH
`define ROW_KERNEL_UPSAMPLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is high.
`define RKU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("row kernel upsampler assertion failed");
// Assertion that is also checked during reset.
`define RKU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("row kernel upsampler assertion failed");
`else
`define RKU_ASSERT(label, clk, rst, prop)
`define RKU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/rku_pkg.sv @@
// ----------------------------------------------------------------------------
// Row kernel upsampler package
// Shared types, register codes and kernel constants.
// ----------------------------------------------------------------------------
package rku_pkg;

   localparam int unsigned MAX_TAPS    = 5;
   localparam int unsigned MAX_FACTOR  = 16;
   localparam int unsigned CELL_STAGES = 6;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_ZOOM  = 2'd0;
   localparam logic [1:0] REG_RECIP = 2'd1;
   localparam logic [1:0] REG_KSEL  = 2'd2;

   // Kernel codes.
   localparam logic [1:0] KS_BOX     = 2'd0;
   localparam logic [1:0] KS_TENT    = 2'd1;
   localparam logic [1:0] KS_BELL    = 2'd2;
   localparam logic [1:0] KS_MITCHELL = 2'd3;

   // Mitchell-Netravali coefficients (B = C = 1/3) in Q2.14.
   localparam logic [15:0] MN_A3 = 16'd19115;
   localparam logic [15:0] MN_A0 = 16'd14564;
   localparam logic [15:0] MN_B3 = 16'd6372;
   localparam logic [15:0] MN_B1 = 16'd54613;
   localparam logic [15:0] MN_B0 = 16'd29127;

   typedef struct packed {
      logic [4:0]  zoom;
      logic [16:0] recip;
      logic [1:0]  ksel;
   } cfg_type;

   typedef struct packed {
      logic ce;
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic valid;
      logic run_last;
      logic row_end;
   } tag_type;

endpackage

@@ rtl/row_kernel_upsampler_top.sv @@
// ----------------------------------------------------------------------------
// Row kernel upsampler
// Upsamples one image row by an integer factor with a selectable kernel.
// ----------------------------------------------------------------------------
// Each request carries one source pixel of a row; the block answers with the
// interpolated output pixels of the pixel two places earlier, zoom_factor of
// them (1 to 16), one per cycle, and the request flagged as the row's last
// pixel flushes the rest of the row (up to three groups) with the last pixel
// replicated at the right edge. The single phase sequencer issues one output
// phase per cycle into the row of five tap cells while the pipeline is not
// stalled. An output passes through the tap cell pipeline, the sum register
// and the output register, and the whole pipeline stalls while an output
// waits to be taken.
`include "row_kernel_upsampler_top_assert.svh"

module row_kernel_upsampler_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] src_pixel
   input  logic        req_tlast,   // row_last
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] dst_pixel
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // [0] row_end
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Sequencer states: waiting for a request, replicating the last pixel
   // into the window before a flush, and issuing output phases.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SHIFT = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   localparam int unsigned TAG_DEPTH = rku_pkg::CELL_STAGES + 1;

   rku_pkg::cfg_type      cfg;
   rku_pkg::cell_ctl_type cell_ctl;

   logic [1:0]  state_ff, state_in;
   logic        active_ff, active_in;
   logic [11:0] src_idx_ff, src_idx_in;
   logic [7:0]  hold_px_ff, hold_px_in;
   logic        last_ff, last_in;
   logic [3:0]  r_cnt_ff, r_cnt_in;
   logic [20:0] phase_acc_ff, phase_acc_in;
   logic [1:0]  groups_ff, groups_in;
   logic [1:0]  shifts_ff, shifts_in;

   logic        accept;
   logic        ce;
   logic        issue;
   logic        group_end;
   logic [3:0]  f_last;
   logic [15:0] phase_sat;
   logic [7:0]  fill_px;
   logic [1:0]  g_flush;

   rku_pkg::tag_type tag_ff [TAG_DEPTH];
   rku_pkg::tag_type issue_tag;

   logic [7:0]         win_px [rku_pkg::MAX_TAPS];
   logic [7:0]         nbr_px [rku_pkg::MAX_TAPS];
   logic signed [28:0] prod   [rku_pkg::MAX_TAPS];

   logic signed [31:0] sum_in, sum_ff;
   logic [7:0]         sat_px;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_px_ff;
   logic        rsp_last_ff;
   logic        rsp_end_ff;

   rku_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The pipeline moves only when the output register is free or drains.
   assign ce         = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue      = (state_ff == ST_EMIT) && ce;
   assign group_end  = issue && (r_cnt_ff == f_last);

   // A zoom of zero acts as one, and anything above the maximum as the maximum.
   always_comb begin
      if (cfg.zoom == 5'd0) begin
         f_last = 4'd0;
      end else if (cfg.zoom > 5'(rku_pkg::MAX_FACTOR)) begin
         f_last = 4'(rku_pkg::MAX_FACTOR - 1);
      end else begin
         f_last = 4'(cfg.zoom - 5'd1);
      end
   end

   // The phase is the running sum of the phase step, clipped below one pixel.
   assign phase_sat = (phase_acc_ff > 21'd65535) ? 16'hFFFF : phase_acc_ff[15:0];

   // Pixel shifted in: the new request on accept, the held last pixel on a flush.
   assign fill_px = accept ? req_tdata : hold_px_ff;

   always_comb begin
      cell_ctl.ce    = ce;
      cell_ctl.load  = accept && !active_ff;
      cell_ctl.shift = (accept && active_ff) || (state_ff == ST_SHIFT)
                    || (group_end && (groups_ff != 2'd1));
   end

   always_comb begin
      issue_tag.valid    = issue;
      issue_tag.run_last = group_end && (groups_ff == 2'd1);
      issue_tag.row_end  = group_end && (groups_ff == 2'd1) && last_ff;
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      src_idx_in   = src_idx_ff;
      hold_px_in   = hold_px_ff;
      last_in      = last_ff;
      r_cnt_in     = r_cnt_ff;
      phase_acc_in = phase_acc_ff;
      groups_in    = groups_ff;
      shifts_in    = shifts_ff;
      g_flush      = 2'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_px_in   = req_tdata;
               last_in      = req_tlast;
               r_cnt_in     = 4'd0;
               phase_acc_in = 21'd0;
               if (!active_ff) begin
                  src_idx_in = 12'd0;
               end else if (src_idx_ff != 12'hFFF) begin
                  src_idx_in = src_idx_ff + 12'd1;
               end
               if (!req_tlast) begin
                  active_in = 1'b1;
                  groups_in = 2'd1;
                  if (src_idx_in >= 12'd2) begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  // Flush: up to two more groups after the current one.
                  active_in = 1'b0;
                  g_flush   = (src_idx_in >= 12'd2) ? 2'd2 : src_idx_in[1:0];
                  groups_in = g_flush + 2'd1;
                  shifts_in = 2'd2 - g_flush;
                  state_in  = (g_flush == 2'd2) ? ST_EMIT : ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            shifts_in = shifts_ff - 2'd1;
            if (shifts_ff == 2'd1) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               if (group_end) begin
                  r_cnt_in     = 4'd0;
                  phase_acc_in = 21'd0;
                  groups_in    = groups_ff - 2'd1;
                  if (groups_ff == 2'd1) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  r_cnt_in     = r_cnt_ff + 4'd1;
                  phase_acc_in = phase_acc_ff + {4'd0, cfg.recip};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         src_idx_ff   <= 12'd0;
         r_cnt_ff     <= 4'd0;
         phase_acc_ff <= 21'd0;
         groups_ff    <= 2'd0;
         shifts_ff    <= 2'd0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         src_idx_ff   <= src_idx_in;
         r_cnt_ff     <= r_cnt_in;
         phase_acc_ff <= phase_acc_in;
         groups_ff    <= groups_in;
         shifts_ff    <= shifts_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_px_ff <= hold_px_in;
      last_ff    <= last_in;
   end

   // Row of tap cells; the window shifts toward cell zero, which holds the
   // oldest pixel, and the newest pixel enters at the far end.
   for (genvar i = 0; i < rku_pkg::MAX_TAPS; i++) begin : g_tap
      if (i == rku_pkg::MAX_TAPS - 1) begin : g_end
         assign nbr_px[i] = fill_px;
      end else begin : g_mid
         assign nbr_px[i] = win_px[i + 1];
      end

      rku_tap_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .tap_pos (3'(i)),
         .fill_px (fill_px),
         .nbr_px  (nbr_px[i]),
         .phase   (phase_sat),
         .ksel    (cfg.ksel),
         .win_px  (win_px[i]),
         .prod    (prod[i])
      );
   end

   always_comb begin
      sum_in = 32'sd0;
      for (int k = 0; k < rku_pkg::MAX_TAPS; k++) begin
         sum_in = sum_in + 32'(prod[k]);
      end
   end

   // Truncate the signed Q18.14 sum and clip it to the pixel range.
   always_comb begin
      if (sum_ff[31]) begin
         sat_px = 8'd0;
      end else if (sum_ff[30:22] != 9'd0) begin
         sat_px = 8'hFF;
      end else begin
         sat_px = sum_ff[21:14];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAG_DEPTH; k++) begin
            tag_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         tag_ff[0] <= issue_tag;
         for (int k = 1; k < TAG_DEPTH; k++) begin
            tag_ff[k] <= tag_ff[k - 1];
         end
         rsp_valid_ff <= tag_ff[TAG_DEPTH - 1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sum_ff      <= sum_in;
         rsp_px_ff   <= sat_px;
         rsp_last_ff <= tag_ff[TAG_DEPTH - 1].run_last;
         rsp_end_ff  <= tag_ff[TAG_DEPTH - 1].row_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_px_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_end_ff;

   // While phases are issued at least one group must remain.
   `RKU_ASSERT(a_groups_left, clock, reset, (state_ff == ST_EMIT) |-> (groups_ff != 2'd0))
   // The phase counter never passes the effective factor.
   `RKU_ASSERT(a_phase_range, clock, reset, (state_ff == ST_EMIT) |-> (r_cnt_ff <= f_last))
   // A pre-flush shift only runs with shifts pending.
   `RKU_ASSERT(a_shift_count, clock, reset, (state_ff == ST_SHIFT) |-> (shifts_ff != 2'd0))
   // The row end only comes on the last result of a request.
   `RKU_ASSERT(a_row_end_last, clock, reset, (rsp_valid_ff && rsp_end_ff) |-> rsp_last_ff)
   // Nothing is offered right after reset.
   `RKU_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid_ff)

endmodule

@@ rtl/rku_csr.sv @@
// ----------------------------------------------------------------------------
// Row kernel upsampler register file
// APB-style configuration registers for factor, phase step and kernel.
// ----------------------------------------------------------------------------
module rku_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output rku_pkg::cfg_type   cfg
);

   rku_pkg::cfg_type cfg_ff;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zoom  <= 5'd1;
         cfg_ff.recip <= 17'h10000;
         cfg_ff.ksel  <= rku_pkg::KS_BOX;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            rku_pkg::REG_ZOOM:  cfg_ff.zoom  <= csr_pwdata[4:0];
            rku_pkg::REG_RECIP: cfg_ff.recip <= csr_pwdata[16:0];
            rku_pkg::REG_KSEL:  cfg_ff.ksel  <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         rku_pkg::REG_ZOOM:  csr_prdata = {27'd0, cfg_ff.zoom};
         rku_pkg::REG_RECIP: csr_prdata = {15'd0, cfg_ff.recip};
         rku_pkg::REG_KSEL:  csr_prdata = {30'd0, cfg_ff.ksel};
         default:            csr_prdata = 32'd0;
      endcase
   end

endmodule

@@ rtl/rku_tap_cell.sv @@
// ----------------------------------------------------------------------------
// Row kernel upsampler tap cell
// Holds one window pixel, passes it to its neighbor and computes its
// kernel weight and weighted product in a six-stage pipeline.
// ----------------------------------------------------------------------------
module rku_tap_cell (
   input  logic                      clock,
   input  rku_pkg::cell_ctl_type     ctl,
   input  logic [2:0]                tap_pos,
   input  logic [7:0]                fill_px,
   input  logic [7:0]                nbr_px,
   input  logic [15:0]               phase,
   input  logic [1:0]                ksel,
   output logic [7:0]                win_px,
   output logic signed [28:0]        prod
);

   logic [7:0] win_ff;

   // Stage 1: distance.
   logic signed [3:0]  offs;
   logic signed [19:0] x_in;
   logic [19:0]        xabs_in;
   logic [17:0]        a1_ff;
   logic               box1_ff;
   logic [7:0]         px1_ff;

   // Stage 2: squares.
   logic [35:0] sq_in;
   logic [16:0] b_in;
   logic [33:0] bsq_in;
   logic [17:0] a2_ff;
   logic [19:0] aa2_ff;
   logic [16:0] bb2_ff;
   logic        box2_ff;
   logic [7:0]  px2_ff;

   // Stage 3: cube and simple kernels.
   logic [37:0] cube_in;
   logic [16:0] tent_in;
   logic [15:0] ws_in;
   logic [17:0] a3_ff;
   logic [19:0] aa3_ff;
   logic [21:0] cub3_ff;
   logic [15:0] ws3_ff;
   logic [7:0]  px3_ff;

   // Stage 4: Mitchell products.
   logic [36:0] p1_in;
   logic [34:0] p2_in;
   logic [33:0] p3_in;
   logic [17:0] a4_ff;
   logic [19:0] aa4_ff;
   logic [20:0] m1_ff;
   logic [18:0] m2_ff;
   logic [17:0] m3_ff;
   logic [15:0] ws4_ff;
   logic [7:0]  px4_ff;

   // Stage 5: weight.
   logic signed [23:0] w_in;
   logic signed [19:0] w5_ff;
   logic [7:0]         px5_ff;

   // Stage 6: product.
   logic signed [28:0] prod_in;
   logic signed [28:0] prod6_ff;

   assign win_px = win_ff;
   assign prod   = prod6_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         win_ff <= fill_px;
      end else if (ctl.shift) begin
         win_ff <= nbr_px;
      end
   end

   always_comb begin
      offs    = $signed({1'b0, tap_pos}) - 4'sd2;
      x_in    = $signed({offs, 16'h0000}) - $signed({4'h0, phase});
      xabs_in = x_in[19] ? 20'(-x_in) : x_in;

      sq_in  = {18'd0, a1_ff} * {18'd0, a1_ff};
      b_in   = (a1_ff <= 18'd98304) ? 17'(18'd98304 - a1_ff) : 17'd0;
      bsq_in = {17'd0, b_in} * {17'd0, b_in};

      cube_in = {18'd0, aa2_ff} * {20'd0, a2_ff};
      tent_in = 17'(18'd65536 - a2_ff);
      case (ksel)
         rku_pkg::KS_BOX:  ws_in = box2_ff ? 16'd16384 : 16'd0;
         rku_pkg::KS_TENT: ws_in = (a2_ff <= 18'd65536) ? {1'b0, tent_in[16:2]} : 16'd0;
         rku_pkg::KS_BELL: begin
            if (a2_ff <= 18'd32768) begin
               ws_in = 16'(20'(20'd49152 - aa2_ff) >> 2);
            end else if (a2_ff <= 18'd98304) begin
               ws_in = {1'b0, bb2_ff[16:2]};
            end else begin
               ws_in = 16'd0;
            end
         end
         default: ws_in = 16'd0;
      endcase

      p1_in = 37'(rku_pkg::MN_A3) * 37'(cub3_ff);
      p2_in = 35'(rku_pkg::MN_B3) * 35'(cub3_ff);
      p3_in = 34'(rku_pkg::MN_B1) * 34'(a3_ff);

      if (ksel != rku_pkg::KS_MITCHELL) begin
         w_in = $signed({8'd0, ws4_ff});
      end else if (a4_ff <= 18'd65536) begin
         w_in = $signed({3'd0, m1_ff}) - $signed({5'd0, aa4_ff[19:1]})
              + $signed({8'd0, rku_pkg::MN_A0});
      end else if (a4_ff <= 18'd131072) begin
         w_in = $signed({5'd0, aa4_ff[19:1]}) - $signed({5'd0, m2_ff})
              - $signed({6'd0, m3_ff}) + $signed({8'd0, rku_pkg::MN_B0});
      end else begin
         w_in = 24'sd0;
      end

      prod_in = $signed({21'd0, px5_ff}) * $signed({{9{w5_ff[19]}}, w5_ff});
   end

   always_ff @(posedge clock) begin
      if (ctl.ce) begin
         a1_ff    <= xabs_in[17:0];
         box1_ff  <= (x_in >= -20'sd32768) && (x_in < 20'sd32768);
         px1_ff   <= win_ff;

         a2_ff    <= a1_ff;
         aa2_ff   <= sq_in[35:16];
         bb2_ff   <= bsq_in[33:17];
         box2_ff  <= box1_ff;
         px2_ff   <= px1_ff;

         a3_ff    <= a2_ff;
         aa3_ff   <= aa2_ff;
         cub3_ff  <= cube_in[37:16];
         ws3_ff   <= ws_in;
         px3_ff   <= px2_ff;

         a4_ff    <= a3_ff;
         aa4_ff   <= aa3_ff;
         m1_ff    <= p1_in[36:16];
         m2_ff    <= p2_in[34:16];
         m3_ff    <= p3_in[33:16];
         ws4_ff   <= ws3_ff;
         px4_ff   <= px3_ff;

         w5_ff    <= w_in[19:0];
         px5_ff   <= px4_ff;

         prod6_ff <= prod_in;
      end
   end

endmodule
